// ===== rtl/core/lie_pkg.sv =====
// Shared types, widths and codes for the Lagrange interpolation evaluator.
// No dependencies; every other file in rtl/core imports this package.
package lie_pkg;

    // Datapath word width and the derived arithmetic widths
    localparam int WORD_WIDTH = 32;
    localparam int DW         = (WORD_WIDTH > 32) ? 32 : WORD_WIDTH;
    localparam int FIELD_W    = 32;
    localparam int DIFF_W     = DW + 1;             // exact node difference
    localparam int MAG_W      = DW + 1;             // |difference| up to 2^DW
    localparam int YMAG_W     = DW;                 // |y| up to 2^(DW-1)
    localparam int PROD_W     = 2 * MAG_W;          // product of two magnitudes
    localparam int SPLIT_W    = 32;                 // low slice of the wide product
    localparam int PL_W       = SPLIT_W + YMAG_W;
    localparam int PH_W       = PROD_W - SPLIT_W + YMAG_W;
    localparam int NUM_W      = PROD_W + YMAG_W + 1; // 2*num + den
    localparam int DEN2_W     = PROD_W + 1;          // 2*den
    localparam int Q_W        = 61;                  // quotient bits below the clamp
    localparam int TERM_W     = Q_W + 1;             // signed clamped term
    localparam int SUM_W      = TERM_W + 2;
    localparam int NTERMS     = 3;

    localparam logic [Q_W-1:0] TERM_LIMIT = Q_W'(1) << (Q_W - 1);

    // APB port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_NODE_X0  = 3'd0,
        REG_NODE_X1  = 3'd1,
        REG_NODE_X2  = 3'd2,
        REG_VALUE_Y0 = 3'd3,
        REG_VALUE_Y1 = 3'd4,
        REG_VALUE_Y2 = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_COINCIDENT  = 2'd1,
        ST_SATURATED   = 2'd2,
        ST_UNSUPPORTED = 2'd3
    } status_t;

    localparam logic [1:0] ORDER_LINEAR = 2'd1;
    localparam logic [1:0] ORDER_QUAD   = 2'd2;

    typedef struct packed {
        logic signed [FIELD_W-1:0] query_x;
        logic        [1:0]         poly_order;
    } query_beat_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] interp_value;
        logic        [1:0]         status;
    } result_beat_t;

    typedef struct packed {
        logic [FIELD_W-1:0] node_x0;
        logic [FIELD_W-1:0] node_x1;
        logic [FIELD_W-1:0] node_x2;
        logic [FIELD_W-1:0] value_y0;
        logic [FIELD_W-1:0] value_y1;
        logic [FIELD_W-1:0] value_y2;
    } node_cfg_t;

    // One term entering the divider
    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [DEN2_W-1:0] den;
        logic              neg;
    } div_lane_t;

    // One term leaving the divider
    typedef struct packed {
        logic [Q_W-1:0] quo;
        logic           ovf;
        logic           neg;
    } quo_lane_t;

    // Sign extend the low DW bits of a field to the difference width
    function automatic logic signed [DIFF_W-1:0] sext_dw(input logic [FIELD_W-1:0] v);
        logic signed [DW-1:0] low;
        low = signed'(v[DW-1:0]);
        return DIFF_W'(low);
    endfunction

    // Magnitude of a signed difference
    function automatic logic [MAG_W-1:0] mag_of(input logic signed [DIFF_W-1:0] v);
        logic signed [DIFF_W-1:0] n;
        n = -v;
        return v[DIFF_W-1] ? MAG_W'(n) : MAG_W'(v);
    endfunction

endpackage

// ===== rtl/core/lie_cfg.sv =====
// APB register file holding the three interpolation nodes.
// Depends on lie_pkg.
module lie_cfg (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [lie_pkg::PADDR_W-1:0] paddr,
    input  logic [lie_pkg::PDATA_W-1:0] pwdata,
    output logic [lie_pkg::PDATA_W-1:0] prdata,
    output logic                    pready,
    output lie_pkg::node_cfg_t      nodes
);
    import lie_pkg::*;

    node_cfg_t nodes_reg;
    node_cfg_t nodes_next;
    reg_idx_t  idx;
    logic      wr_en;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign nodes  = nodes_reg;

    // Register write decode; addresses past the list are ignored
    always_comb
    begin
        nodes_next = nodes_reg;
        if (wr_en)
        begin
            case (idx)
                REG_NODE_X0:  nodes_next.node_x0  = pwdata;
                REG_NODE_X1:  nodes_next.node_x1  = pwdata;
                REG_NODE_X2:  nodes_next.node_x2  = pwdata;
                REG_VALUE_Y0: nodes_next.value_y0 = pwdata;
                REG_VALUE_Y1: nodes_next.value_y1 = pwdata;
                REG_VALUE_Y2: nodes_next.value_y2 = pwdata;
                default:      nodes_next = nodes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_reg <= '0;
        end
        else
        begin
            nodes_reg <= nodes_next;
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            REG_NODE_X0:  prdata = nodes_reg.node_x0;
            REG_NODE_X1:  prdata = nodes_reg.node_x1;
            REG_NODE_X2:  prdata = nodes_reg.node_x2;
            REG_VALUE_Y0: prdata = nodes_reg.value_y0;
            REG_VALUE_Y1: prdata = nodes_reg.value_y1;
            REG_VALUE_Y2: prdata = nodes_reg.value_y2;
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/lie_front.sv =====
// Front end: node differences, magnitudes and the numerator/denominator
// products of the three Lagrange terms, six register stages. Depends on lie_pkg.
module lie_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  lie_pkg::query_beat_t query,
    input  lie_pkg::node_cfg_t  nodes,
    output logic                out_valid,
    output lie_pkg::div_lane_t  lanes [lie_pkg::NTERMS],
    output lie_pkg::status_t    pre_status
);
    import lie_pkg::*;

    // valid and status travel with every stage
    logic    vld_reg [6];
    status_t st_reg  [6];

    // stage 1: signed differences
    logic signed [DIFF_W-1:0] na_next [NTERMS], nb_next [NTERMS];
    logic signed [DIFF_W-1:0] da_next [NTERMS], db_next [NTERMS];
    logic signed [DIFF_W-1:0] y_next  [NTERMS];
    logic signed [DIFF_W-1:0] na_reg  [NTERMS], nb_reg  [NTERMS];
    logic signed [DIFF_W-1:0] da_reg  [NTERMS], db_reg  [NTERMS];
    logic signed [DIFF_W-1:0] y_reg   [NTERMS];
    status_t                  st_next;

    // stage 2: magnitudes and term sign
    logic [MAG_W-1:0]  ma_reg [NTERMS], mb_reg [NTERMS];
    logic [MAG_W-1:0]  mc_reg [NTERMS], md_reg [NTERMS];
    logic [YMAG_W-1:0] ym2_reg [NTERMS];
    logic              neg2_reg [NTERMS];

    // stage 3: magnitude products
    logic [PROD_W-1:0] p_reg [NTERMS], d3_reg [NTERMS];
    logic [YMAG_W-1:0] ym3_reg [NTERMS];
    logic              neg3_reg [NTERMS];

    // stage 4: partial products of numerator times |y|
    logic [PL_W-1:0]   pl_reg [NTERMS];
    logic [PH_W-1:0]   ph_reg [NTERMS];
    logic [PROD_W-1:0] d4_reg [NTERMS];
    logic              neg4_reg [NTERMS];

    // stage 5: full numerator
    logic [NUM_W-1:0]  num_reg [NTERMS];
    logic [PROD_W-1:0] d5_reg [NTERMS];
    logic              neg5_reg [NTERMS];

    // stage 6: rounding offset folded in
    div_lane_t lane_reg [NTERMS];

    // Operand selection per order
    always_comb
    begin
        logic signed [DIFF_W-1:0] x, x0, x1, x2, one;
        logic quad, lin;
        x    = sext_dw(query.query_x);
        x0   = sext_dw(nodes.node_x0);
        x1   = sext_dw(nodes.node_x1);
        x2   = sext_dw(nodes.node_x2);
        one  = DIFF_W'(1);
        quad = (query.poly_order == ORDER_QUAD);
        lin  = (query.poly_order == ORDER_LINEAR);

        na_next[0] = x - x1;
        nb_next[0] = quad ? x - x2 : one;
        da_next[0] = x0 - x1;
        db_next[0] = quad ? x0 - x2 : one;
        y_next[0]  = sext_dw(nodes.value_y0);

        na_next[1] = x - x0;
        nb_next[1] = quad ? x - x2 : one;
        da_next[1] = x1 - x0;
        db_next[1] = quad ? x1 - x2 : one;
        y_next[1]  = sext_dw(nodes.value_y1);

        // third term is zero for the linear case
        na_next[2] = quad ? x - x0 : '0;
        nb_next[2] = quad ? x - x1 : '0;
        da_next[2] = quad ? x2 - x0 : one;
        db_next[2] = quad ? x2 - x1 : one;
        y_next[2]  = quad ? sext_dw(nodes.value_y2) : '0;

        priority if (!lin && !quad)
            st_next = ST_UNSUPPORTED;
        else if ((x0 == x1) || (quad && ((x0 == x2) || (x1 == x2))))
            st_next = ST_COINCIDENT;
        else
            st_next = ST_OK;
    end

    // Valid and status shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 6; s++)
            begin
                vld_reg[s] <= 1'b0;
                st_reg[s]  <= ST_OK;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid;
            st_reg[0]  <= st_next;
            for (int s = 1; s < 6; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
                st_reg[s]  <= st_reg[s-1];
            end
        end
    end

    // Datapath stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < NTERMS; k++)
            begin
                na_reg[k] <= na_next[k];
                nb_reg[k] <= nb_next[k];
                da_reg[k] <= da_next[k];
                db_reg[k] <= db_next[k];
                y_reg[k]  <= y_next[k];

                ma_reg[k]   <= mag_of(na_reg[k]);
                mb_reg[k]   <= mag_of(nb_reg[k]);
                mc_reg[k]   <= mag_of(da_reg[k]);
                md_reg[k]   <= mag_of(db_reg[k]);
                ym2_reg[k]  <= YMAG_W'(mag_of(y_reg[k]));
                neg2_reg[k] <= na_reg[k][DIFF_W-1] ^ nb_reg[k][DIFF_W-1]
                             ^ da_reg[k][DIFF_W-1] ^ db_reg[k][DIFF_W-1]
                             ^ y_reg[k][DIFF_W-1];

                p_reg[k]    <= PROD_W'(ma_reg[k]) * PROD_W'(mb_reg[k]);
                d3_reg[k]   <= PROD_W'(mc_reg[k]) * PROD_W'(md_reg[k]);
                ym3_reg[k]  <= ym2_reg[k];
                neg3_reg[k] <= neg2_reg[k];

                pl_reg[k]   <= PL_W'(p_reg[k][SPLIT_W-1:0]) * PL_W'(ym3_reg[k]);
                ph_reg[k]   <= PH_W'(p_reg[k][PROD_W-1:SPLIT_W]) * PH_W'(ym3_reg[k]);
                d4_reg[k]   <= d3_reg[k];
                neg4_reg[k] <= neg3_reg[k];

                num_reg[k]  <= NUM_W'(pl_reg[k]) + (NUM_W'(ph_reg[k]) << SPLIT_W);
                d5_reg[k]   <= d4_reg[k];
                neg5_reg[k] <= neg4_reg[k];

                lane_reg[k].num <= (num_reg[k] << 1) + NUM_W'(d5_reg[k]);
                lane_reg[k].den <= DEN2_W'(d5_reg[k]) << 1;
                lane_reg[k].neg <= neg5_reg[k];
            end
        end
    end

    assign out_valid  = vld_reg[5];
    assign pre_status = st_reg[5];
    assign lanes      = lane_reg;

endmodule

// ===== rtl/core/lie_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, three lanes wide.
// First stage flags quotients past the clamp range. Depends on lie_pkg.
module lie_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               in_valid,
    input  lie_pkg::div_lane_t lanes_in [lie_pkg::NTERMS],
    input  lie_pkg::status_t   status_in,
    output logic               out_valid,
    output lie_pkg::quo_lane_t lanes_out [lie_pkg::NTERMS],
    output lie_pkg::status_t   status_out
);
    import lie_pkg::*;

    localparam int NST = Q_W + 1;

    logic              vld_reg [NST];
    status_t           st_reg  [NST];
    logic [NUM_W-1:0]  rem_reg [NST][NTERMS];
    logic [DEN2_W-1:0] den_reg [NST][NTERMS];
    logic [Q_W-1:0]    quo_reg [NST][NTERMS];
    logic              ovf_reg [NST][NTERMS];
    logic              neg_reg [NST][NTERMS];

    // Control shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NST; s++)
            begin
                vld_reg[s] <= 1'b0;
                st_reg[s]  <= ST_OK;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid;
            st_reg[0]  <= status_in;
            for (int s = 1; s < NST; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
                st_reg[s]  <= st_reg[s-1];
            end
        end
    end

    // Range check: quotient of 2^Q_W or more always clamps
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < NTERMS; k++)
            begin
                rem_reg[0][k] <= lanes_in[k].num;
                den_reg[0][k] <= lanes_in[k].den;
                quo_reg[0][k] <= '0;
                ovf_reg[0][k] <= (NUM_W'(lanes_in[k].num >> Q_W) >= NUM_W'(lanes_in[k].den));
                neg_reg[0][k] <= lanes_in[k].neg;
            end
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar s = 1; s < NST; s++)
    begin : g_step
        localparam int B = Q_W - s;

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                for (int k = 0; k < NTERMS; k++)
                begin
                    if ((rem_reg[s-1][k] >> B) >= NUM_W'(den_reg[s-1][k]))
                    begin
                        rem_reg[s][k]    <= rem_reg[s-1][k] - (NUM_W'(den_reg[s-1][k]) << B);
                        quo_reg[s][k]    <= quo_reg[s-1][k] | (Q_W'(1) << B);
                    end
                    else
                    begin
                        rem_reg[s][k]    <= rem_reg[s-1][k];
                        quo_reg[s][k]    <= quo_reg[s-1][k];
                    end
                    den_reg[s][k] <= den_reg[s-1][k];
                    ovf_reg[s][k] <= ovf_reg[s-1][k];
                    neg_reg[s][k] <= neg_reg[s-1][k];
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NTERMS; k++)
        begin
            lanes_out[k].quo = quo_reg[NST-1][k];
            lanes_out[k].ovf = ovf_reg[NST-1][k];
            lanes_out[k].neg = neg_reg[NST-1][k];
        end
    end

    assign out_valid  = vld_reg[NST-1];
    assign status_out = st_reg[NST-1];

endmodule

// ===== rtl/core/lie_back.sv =====
// Back end: term clamping, three-term sum, word saturation and the result
// register, three stages. Depends on lie_pkg.
module lie_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 in_valid,
    input  lie_pkg::quo_lane_t   lanes [lie_pkg::NTERMS],
    input  lie_pkg::status_t     status_in,
    output logic                 out_valid,
    output lie_pkg::result_beat_t result
);
    import lie_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (DW - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    logic    vld_reg [3];
    status_t st_reg  [3];

    logic signed [TERM_W-1:0] term_reg [NTERMS];
    logic                     clamp1_reg, clamp2_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    result_beat_t             result_reg;

    logic signed [TERM_W-1:0] term_next [NTERMS];
    logic                     clamp_next;
    result_beat_t             result_next;

    // Clamp each rounded term and apply its sign
    always_comb
    begin
        logic [Q_W-1:0] m;
        logic           c;
        clamp_next = 1'b0;
        for (int k = 0; k < NTERMS; k++)
        begin
            c = lanes[k].ovf || (lanes[k].quo > TERM_LIMIT);
            m = c ? TERM_LIMIT : lanes[k].quo;
            term_next[k] = lanes[k].neg ? -signed'(TERM_W'(m)) : signed'(TERM_W'(m));
            clamp_next = clamp_next | c;
        end
    end

    // Saturate and pick the status
    always_comb
    begin
        logic signed [DW-1:0] v;
        logic                 sat;
        sat = 1'b0;
        if (sum_reg > SAT_HI)
        begin
            v   = DW'(SAT_HI);
            sat = 1'b1;
        end
        else if (sum_reg < SAT_LO)
        begin
            v   = DW'(SAT_LO);
            sat = 1'b1;
        end
        else
        begin
            v = DW'(sum_reg);
        end

        if (st_reg[1] != ST_OK)
        begin
            result_next.interp_value = '0;
            result_next.status       = st_reg[1];
        end
        else
        begin
            result_next.interp_value = FIELD_W'(v);
            result_next.status       = (sat || clamp2_reg) ? ST_SATURATED : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 3; s++)
            begin
                vld_reg[s] <= 1'b0;
                st_reg[s]  <= ST_OK;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid;
            st_reg[0]  <= status_in;
            for (int s = 1; s < 3; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
                st_reg[s]  <= st_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            term_reg   <= term_next;
            clamp1_reg <= clamp_next;
            sum_reg    <= SUM_W'(term_reg[0]) + SUM_W'(term_reg[1]) + SUM_W'(term_reg[2]);
            clamp2_reg <= clamp1_reg;
            result_reg <= result_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign result    = result_reg;

endmodule

// ===== rtl/core/lagrange_interpolation_evaluator_unit.sv =====
// Lagrange interpolation evaluator, first and second order, signed Q16.16.
// Front end, divider and back end in series; one query per cycle while the result is not stalled.
// The depth is set by the bit-per-stage divider that rounds each term.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
// rst_n clears all valid bits and the node registers to zero, asynchronously.
module lagrange_interpolation_evaluator_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lie_pkg::PADDR_W-1:0]  paddr,
    input  logic [lie_pkg::PDATA_W-1:0]  pwdata,
    output logic [lie_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         query_valid,
    output logic                         query_ready,
    input  lie_pkg::query_beat_t         query,
    output logic                         result_valid,
    input  logic                         result_ready,
    output lie_pkg::result_beat_t        result
);
    import lie_pkg::*;

    node_cfg_t nodes;
    logic      advance;
    logic      f_valid, d_valid;
    div_lane_t f_lanes [NTERMS];
    quo_lane_t d_lanes [NTERMS];
    status_t   f_status, d_status;

    // pipeline moves whenever the result register is free or drains
    assign advance     = !result_valid || result_ready;
    assign query_ready = advance;

    lie_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .nodes   (nodes)
    );

    lie_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (query_valid),
        .query      (query),
        .nodes      (nodes),
        .out_valid  (f_valid),
        .lanes      (f_lanes),
        .pre_status (f_status)
    );

    lie_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (f_valid),
        .lanes_in   (f_lanes),
        .status_in  (f_status),
        .out_valid  (d_valid),
        .lanes_out  (d_lanes),
        .status_out (d_status)
    );

    lie_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (d_valid),
        .lanes     (d_lanes),
        .status_in (d_status),
        .out_valid (result_valid),
        .result    (result)
    );

    // Unsupported order and coincident nodes always report a zero value
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == ST_UNSUPPORTED || result.status == ST_COINCIDENT)
        |-> result.interp_value == '0)
        else $error("flagged result carries a nonzero value");

    // A held result blocks new queries
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !query_ready)
        else $error("query taken while result stalled");

    // A stalled result stays put on the next cycle
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed");

endmodule
